@@ rtl/core/best_worst_fit_allocator_assert.svh @@
// assertion macros shared by the allocator control and datapath modules
`ifndef BEST_WORST_FIT_ALLOCATOR_ASSERT_SVH
`define BEST_WORST_FIT_ALLOCATOR_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define BWFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bwfa assertion failed");

// consequent checked in the cycle after the antecedent
`define BWFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bwfa assertion failed");

`endif

@@ rtl/core/bwfa_pkg.sv @@
package bwfa_pkg;

  localparam int unsigned CHUNKS_DEF    = 256;
  localparam int unsigned SIZE_BITS_DEF = 16;
  localparam int unsigned AMOUNT_W      = 16;
  localparam int unsigned INDEX_W       = 8;
  localparam int unsigned TOTAL_W       = 32;

  typedef enum logic [0:0] {
    OP_ADD = 1'b0,
    OP_REQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_FIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_ADDED = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    FIT_BEST  = 1'b0,
    FIT_WORST = 1'b1
  } fit_e;

  typedef struct packed {
    op_e                 op;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [INDEX_W-1:0]  chunk_index;
    logic [AMOUNT_W-1:0] remaining;
    logic [TOTAL_W-1:0]  miss_total;
    logic [TOTAL_W-1:0]  allocated_total;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_req;
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] a,
                                                 logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

@@ rtl/core/bwfa_ram.sv @@
module bwfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/bwfa_ctrl.sv @@
`include "best_worst_fit_allocator_assert.svh"

module bwfa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output bwfa_pkg::ctrl_cmd_t    cmd_o,
  input  bwfa_pkg::ctrl_status_t status_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = status_i.is_req ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BWFA_ASSERT(a_finish_free, !cmd_o.finish || status_i.out_free)
  `BWFA_ASSERT(a_cmd_excl, !(cmd_o.scan_en && cmd_o.finish) && !(cmd_o.load && cmd_o.finish))
  `BWFA_ASSERT_NEXT(a_load_busy, cmd_o.load, !in_ready_o)

endmodule

@@ rtl/core/bwfa_dpath.sv @@
`include "best_worst_fit_allocator_assert.svh"

module bwfa_dpath #(
  parameter int unsigned CHUNKS    = bwfa_pkg::CHUNKS_DEF,
  parameter int unsigned SIZE_BITS = bwfa_pkg::SIZE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bwfa_pkg::in_item_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bwfa_pkg::out_item_t    out_data_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  bwfa_pkg::ctrl_cmd_t    cmd_i,
  output bwfa_pkg::ctrl_status_t status_o
);

  localparam int unsigned IDX_W = $clog2(CHUNKS);
  localparam int unsigned CNT_W = $clog2(CHUNKS + 1);
  localparam int unsigned TW    = bwfa_pkg::TOTAL_W;

  logic                 fit_mode_q;
  bwfa_pkg::op_e        op_q;
  logic [SIZE_BITS-1:0] amt_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [TW-1:0]        miss_q, miss_d;
  logic [TW-1:0]        sum_q, sum_d;
  logic [CNT_W-1:0]     rd_idx_q;
  logic                 cmp_valid_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     pick_q;
  logic [SIZE_BITS-1:0] psize_q;
  logic                 out_valid_q;
  bwfa_pkg::out_item_t  out_data_q;

  logic [TW-1:0]        amt_ext;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 take;
  logic                 more;
  logic                 full;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  bwfa_pkg::status_e    res_status;
  logic [IDX_W-1:0]     res_idx;
  logic [SIZE_BITS-1:0] res_rem;
  logic [TW-1:0]        idx_ext;
  logic [TW-1:0]        rem_ext;

  assign amt_ext = TW'(in_data_i.amount);

  bwfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (CHUNKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rd_data)
  );

  assign more = (rd_idx_q < count_q);
  assign take = cmp_valid_q && (rd_data >= amt_q) &&
                (!found_q ||
                 ((fit_mode_q == bwfa_pkg::FIT_BEST)  && (rd_data <= psize_q)) ||
                 ((fit_mode_q == bwfa_pkg::FIT_WORST) && (rd_data >= psize_q)));

  assign full = (count_q == CNT_W'(CHUNKS));

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = count_q[IDX_W-1:0];
    ram_wdata  = '0;
    res_status = bwfa_pkg::ST_FULL;
    res_idx    = '0;
    res_rem    = '0;
    count_d    = count_q;
    miss_d     = miss_q;
    sum_d      = sum_q;
    if (op_q == bwfa_pkg::OP_ADD) begin
      if (!full) begin
        ram_we     = 1'b1;
        ram_wdata  = amt_q;
        res_status = bwfa_pkg::ST_ADDED;
        res_idx    = count_q[IDX_W-1:0];
        res_rem    = amt_q;
        count_d    = count_q + CNT_W'(1);
        sum_d      = bwfa_pkg::sat_add(sum_q, TW'(amt_q));
      end
    end else if (found_q) begin
      ram_we     = 1'b1;
      ram_waddr  = pick_q;
      ram_wdata  = psize_q - amt_q;
      res_status = bwfa_pkg::ST_FIT;
      res_idx    = pick_q;
      res_rem    = psize_q - amt_q;
    end else if (!full) begin
      ram_we     = 1'b1;
      res_status = bwfa_pkg::ST_MISS;
      res_idx    = count_q[IDX_W-1:0];
      count_d    = count_q + CNT_W'(1);
      miss_d     = bwfa_pkg::sat_add(miss_q, TW'(1));
      sum_d      = bwfa_pkg::sat_add(sum_q, TW'(amt_q));
    end
    ram_we = ram_we && cmd_i.finish;
  end

  assign idx_ext = TW'(res_idx);
  assign rem_ext = TW'(res_rem);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q  <= 1'b0;
      count_q     <= '0;
      miss_q      <= '0;
      sum_q       <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fit_mode_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        count_q <= count_d;
        miss_q  <= miss_d;
        sum_q   <= sum_d;
      end
      cmp_valid_q <= cmd_i.scan_en && more;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i.op;
      amt_q    <= amt_ext[SIZE_BITS-1:0];
      rd_idx_q <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.scan_en && more) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (take) begin
        found_q <= 1'b1;
        pick_q  <= cmp_idx_q;
        psize_q <= rd_data;
      end
    end
    cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    if (cmd_i.finish) begin
      out_data_q.status          <= res_status;
      out_data_q.chunk_index     <= idx_ext[bwfa_pkg::INDEX_W-1:0];
      out_data_q.remaining       <= rem_ext[bwfa_pkg::AMOUNT_W-1:0];
      out_data_q.miss_total      <= miss_d;
      out_data_q.allocated_total <= sum_d;
    end
  end

  assign status_o.is_req    = (op_q == bwfa_pkg::OP_REQ);
  assign status_o.scan_done = !more && !cmp_valid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `BWFA_ASSERT(a_count_range, count_q <= CNT_W'(CHUNKS))
  `BWFA_ASSERT(a_count_step,
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
  `BWFA_ASSERT(a_miss_appends, (miss_q == $past(miss_q)) || (count_q != $past(count_q)))

endmodule

@@ rtl/core/best_worst_fit_allocator.sv @@
// best/worst fit chunk allocator
// input channel in_valid_i/in_ready_o carries one item: op and amount. an add
// item appends a free chunk; a request item scans the table and carves the
// request from the smallest (fit_mode 0) or largest (fit_mode 1) chunk that
// fits, the later entry winning ties; with no fit it counts a miss and appends
// a used-up chunk. an add, or a request with no fit, to a full table answers
// status 3 and changes nothing. output channel out_valid_o/out_ready_i returns
// one result item per input item, in order, with running miss and allocated
// totals. fit_mode is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle, which the block itself does not
// enforce. the scan reads one table entry per cycle through the ram read port.
// one item is in work at a time; the next is accepted once the previous result
// sits in the output register, even while the receiver stalls it; a second
// result waits until the register is taken.
// reset clears the chunk count, counters and fit_mode; the table needs no clear.
module best_worst_fit_allocator #(
  parameter int unsigned CHUNKS    = bwfa_pkg::CHUNKS_DEF,
  parameter int unsigned SIZE_BITS = bwfa_pkg::SIZE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bwfa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bwfa_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  bwfa_pkg::ctrl_cmd_t    cmd;
  bwfa_pkg::ctrl_status_t status;

  bwfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  bwfa_dpath #(
    .CHUNKS    (CHUNKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

@@ dv/tb_best_worst_fit_allocator.sv @@
module tb_best_worst_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_DEPTH = bwfa_pkg::CHUNKS_DEF;
  localparam int unsigned AMT_W = bwfa_pkg::AMOUNT_W;
  localparam int unsigned TOT_W = bwfa_pkg::TOTAL_W;
  localparam int unsigned IDX_W = bwfa_pkg::INDEX_W;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES = 500;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  bwfa_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  bwfa_pkg::out_item_t out_data_o;
  logic                cfg_we_i;
  logic                cfg_wdata_i;

  best_worst_fit_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // allocator state as the testbench sees it
  logic [AMT_W-1:0]  free_size [TBL_DEPTH];
  int unsigned       n_chunks = 0;
  logic [TOT_W-1:0]  miss_cnt = '0;
  logic [TOT_W-1:0]  alloc_sum = '0;
  bwfa_pkg::fit_e    cur_mode = bwfa_pkg::FIT_BEST;

  bwfa_pkg::out_item_t owed_grants[$];
  bwfa_pkg::out_item_t grant_want;
  int unsigned fault_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned n_fit = 0;
  int unsigned n_miss = 0;
  int unsigned n_added = 0;
  int unsigned n_full = 0;
  int unsigned tx_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_left;
  int unsigned quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [TOT_W-1:0] add_sat(input logic [TOT_W-1:0] a,
                                                input logic [TOT_W-1:0] b);
    return (a > ({TOT_W{1'b1}} - b)) ? {TOT_W{1'b1}} : a + b;
  endfunction

  function automatic logic [AMT_W-1:0] largest_free();
    logic [AMT_W-1:0] top;
    int unsigned i;
    top = '0;
    for (i = 0; i < n_chunks; i++) begin
      if (free_size[i] > top) top = free_size[i];
    end
    return top;
  endfunction

  function automatic bwfa_pkg::out_item_t carve_chunk(input bwfa_pkg::in_item_t it);
    bwfa_pkg::out_item_t r;
    logic                found;
    int unsigned         pick;
    int unsigned         i;
    logic [AMT_W-1:0]    pick_sz;
    r = '0;
    found = 1'b0;
    pick = 0;
    pick_sz = '0;
    if (it.op == bwfa_pkg::OP_ADD) begin
      if (n_chunks >= TBL_DEPTH) begin
        r.status = bwfa_pkg::ST_FULL;
      end else begin
        free_size[n_chunks] = it.amount;
        r.status = bwfa_pkg::ST_ADDED;
        r.chunk_index = n_chunks[IDX_W-1:0];
        r.remaining = it.amount;
        n_chunks++;
        alloc_sum = add_sat(alloc_sum, TOT_W'(it.amount));
      end
    end else begin
      for (i = 0; i < n_chunks; i++) begin
        if (free_size[i] >= it.amount) begin
          if (!found || (cur_mode == bwfa_pkg::FIT_BEST && free_size[i] <= pick_sz) ||
              (cur_mode == bwfa_pkg::FIT_WORST && free_size[i] >= pick_sz)) begin
            found = 1'b1;
            pick = i;
            pick_sz = free_size[i];
          end
        end
      end
      if (found) begin
        free_size[pick] = pick_sz - it.amount;
        r.status = bwfa_pkg::ST_FIT;
        r.chunk_index = pick[IDX_W-1:0];
        r.remaining = free_size[pick];
      end else if (n_chunks >= TBL_DEPTH) begin
        r.status = bwfa_pkg::ST_FULL;
      end else begin
        free_size[n_chunks] = '0;
        r.status = bwfa_pkg::ST_MISS;
        r.chunk_index = n_chunks[IDX_W-1:0];
        n_chunks++;
        miss_cnt = add_sat(miss_cnt, TOT_W'(1));
        alloc_sum = add_sat(alloc_sum, TOT_W'(it.amount));
      end
    end
    r.miss_total = miss_cnt;
    r.allocated_total = alloc_sum;
    return r;
  endfunction

  // mostly requests that fit a stored chunk, with adds, misses and zero requests mixed in
  function automatic bwfa_pkg::in_item_t random_item();
    bwfa_pkg::in_item_t it;
    int unsigned        roll;
    int unsigned        k;
    int unsigned        tries;
    logic [AMT_W-1:0]   top;
    roll = $urandom_range(99);
    it.op = bwfa_pkg::OP_REQ;
    it.amount = AMT_W'($urandom);
    top = largest_free();
    if (roll < 12) begin
      it.op = bwfa_pkg::OP_ADD;
      if (roll < 2) it.amount = '0;
      else if (roll < 4) it.amount = '1;
      else if (roll < 8) it.amount = AMT_W'($urandom_range(255));
    end else if (roll < 20) begin
      it.op = bwfa_pkg::OP_REQ;
    end else if (roll < 28) begin
      if (top != '1) it.amount = top + 1'b1;
    end else if (roll < 33) begin
      it.amount = '0;
    end else if (n_chunks > 0) begin
      tries = 0;
      k = 0;
      do begin
        k = $urandom_range(n_chunks - 1);
        tries++;
      end while (free_size[k] == '0 && tries < 6);
      it.amount = AMT_W'($urandom_range(free_size[k]));
    end
    return it;
  endfunction

  task automatic send_item(input bwfa_pkg::in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    owed_grants.push_back(carve_chunk(it));
    items_sent++;
  endtask

  task automatic offer(input bwfa_pkg::op_e op, input logic [AMT_W-1:0] amount);
    bwfa_pkg::in_item_t it;
    it.op = op;
    it.amount = amount;
    send_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_fit_mode(input bwfa_pkg::fit_e m);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
  endtask

  task automatic flag_fault(input string what, input logic [TOT_W-1:0] want,
                            input logic [TOT_W-1:0] got);
    fault_cnt++;
    if (fault_cnt <= 10) begin
      $display("mismatch %s: expected 0x%0h got 0x%0h", what, want, got);
    end
  endtask

  task automatic test_directed_corners();
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    set_fit_mode(bwfa_pkg::FIT_BEST);
    offer(bwfa_pkg::OP_REQ, 16'd5);
    offer(bwfa_pkg::OP_ADD, 16'd0);
    offer(bwfa_pkg::OP_ADD, 16'hFFFF);
    offer(bwfa_pkg::OP_ADD, 16'd100);
    offer(bwfa_pkg::OP_ADD, 16'd100);
    offer(bwfa_pkg::OP_ADD, 16'd300);
    offer(bwfa_pkg::OP_REQ, 16'd50);
    offer(bwfa_pkg::OP_REQ, 16'd0);
    offer(bwfa_pkg::OP_REQ, 16'hFFFF);
    offer(bwfa_pkg::OP_REQ, 16'hFFFF);
    set_fit_mode(bwfa_pkg::FIT_WORST);
    offer(bwfa_pkg::OP_REQ, 16'd10);
    offer(bwfa_pkg::OP_ADD, 16'd290);
    offer(bwfa_pkg::OP_REQ, 16'd1);
    offer(bwfa_pkg::OP_REQ, 16'd0);
    offer(bwfa_pkg::OP_REQ, 16'd400);
    offer(bwfa_pkg::OP_REQ, 16'h8000);
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n);
    int unsigned i;
    tx_gap_pct = tx_pct;
    rx_stall_pct = rx_pct;
    set_fit_mode(bwfa_pkg::FIT_WORST);
    for (i = 0; i < n / 2; i++) send_item(random_item());
    set_fit_mode(bwfa_pkg::FIT_BEST);
    for (i = n / 2; i < n; i++) send_item(random_item());
  endtask

  task automatic test_output_backpressure();
    int unsigned i;
    drain_results();
    tx_gap_pct = 0;
    rx_stall_pct = 30;
    @(posedge clk_i);
    hold_ask = HOLD_CYCLES;
    for (i = 0; i < 8; i++) send_item(random_item());
    drain_results();
    for (i = 0; i < 8; i++) send_item(random_item());
  endtask

  task automatic test_table_full();
    tx_gap_pct = 10;
    rx_stall_pct = 10;
    set_fit_mode(bwfa_pkg::FIT_WORST);
    while (n_chunks < TBL_DEPTH) offer(bwfa_pkg::OP_ADD, AMT_W'($urandom_range(4095)));
    offer(bwfa_pkg::OP_ADD, '1);
    offer(bwfa_pkg::OP_ADD, '0);
    while (largest_free() == '1) offer(bwfa_pkg::OP_REQ, '1);
    offer(bwfa_pkg::OP_REQ, largest_free() + 1'b1);
    offer(bwfa_pkg::OP_REQ, '0);
    offer(bwfa_pkg::OP_REQ, AMT_W'($urandom_range(largest_free())));
    set_fit_mode(bwfa_pkg::FIT_BEST);
    offer(bwfa_pkg::OP_REQ, '0);
    offer(bwfa_pkg::OP_REQ, 16'd1);
    offer(bwfa_pkg::OP_REQ, largest_free() + 1'b1);
    offer(bwfa_pkg::OP_ADD, AMT_W'($urandom));
  endtask

  // receiver side, with a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask = 0;
        out_ready_i <= 1'b0;
        repeat (hold_left) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_grants.size() == 0) begin
        flag_fault("result with nothing owed, status", '0, TOT_W'(out_data_o.status));
      end else begin
        grant_want = owed_grants.pop_front();
        if (out_data_o.status !== grant_want.status)
          flag_fault("status", TOT_W'(grant_want.status), TOT_W'(out_data_o.status));
        if (out_data_o.chunk_index !== grant_want.chunk_index)
          flag_fault("chunk_index", TOT_W'(grant_want.chunk_index),
                     TOT_W'(out_data_o.chunk_index));
        if (out_data_o.remaining !== grant_want.remaining)
          flag_fault("remaining", TOT_W'(grant_want.remaining),
                     TOT_W'(out_data_o.remaining));
        if (out_data_o.miss_total !== grant_want.miss_total)
          flag_fault("miss_total", grant_want.miss_total, out_data_o.miss_total);
        if (out_data_o.allocated_total !== grant_want.allocated_total)
          flag_fault("allocated_total", grant_want.allocated_total,
                     out_data_o.allocated_total);
        case (grant_want.status)
          bwfa_pkg::ST_FIT:   n_fit++;
          bwfa_pkg::ST_MISS:  n_miss++;
          bwfa_pkg::ST_ADDED: n_added++;
          default:            n_full++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_corners();
    test_random_traffic(23, 83, 400);
    test_random_traffic(83, 23, 400);
    test_random_traffic(0, 0, 400);
    test_output_backpressure();
    test_table_full();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (owed_grants.size() != 0) begin
      $display("%0d results never arrived", owed_grants.size());
      fault_cnt += owed_grants.size();
    end
    $display("%0d items in best and worst fit: %0d fits, %0d misses, %0d adds, %0d full",
             items_sent, n_fit, n_miss, n_added, n_full);
    $display("table reached %0d of %0d entries, %0d field mismatches",
             n_chunks, TBL_DEPTH, fault_cnt);
    if (fault_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ best_worst_fit_allocator.f @@
+incdir+rtl/core
rtl/core/bwfa_pkg.sv
rtl/core/bwfa_ram.sv
rtl/core/bwfa_ctrl.sv
rtl/core/bwfa_dpath.sv
rtl/core/best_worst_fit_allocator.sv
dv/tb_best_worst_fit_allocator.sv
